@@ rtl/tfn_pkg.sv @@
// Package: widths, pipeline types and constants of the triangle face normal block.
package tfn_pkg;
   localparam int COORD_W = 16;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int FRAC_SH = 28;
   localparam int QBITS   = 15;
   localparam int ACC_W   = SQ_W + FRAC_SH + 2;
   localparam int SUM_W   = SQ_W + QBITS + 1;
   localparam int OUT_W   = 16;
   localparam int LANES   = 3;
   localparam int FRONT_STAGES = 5;
   localparam int LATENCY = FRONT_STAGES + QBITS + 1;

   typedef struct packed {
      logic [ACC_W-1:0] rem;
      logic [SUM_W-1:0] acc;
      logic [QBITS-1:0] q;
   } lane_type;

   typedef struct packed {
      logic                    valid;
      logic                    deg;
      logic [LANES-1:0]        neg;
      logic [SQ_W-1:0]         len2;
      lane_type [LANES-1:0]    lane;
   } stage_type;
endpackage

@@ rtl/tfn_front.sv @@
// Front pipeline: edges, cross product, magnitudes, squares and squared length.
module tfn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [tfn_pkg::COORD_W-1:0]   ax,
   input  logic [tfn_pkg::COORD_W-1:0]   ay,
   input  logic [tfn_pkg::COORD_W-1:0]   az,
   input  logic [tfn_pkg::COORD_W-1:0]   bx,
   input  logic [tfn_pkg::COORD_W-1:0]   by_coord,
   input  logic [tfn_pkg::COORD_W-1:0]   bz,
   input  logic [tfn_pkg::COORD_W-1:0]   cx_in,
   input  logic [tfn_pkg::COORD_W-1:0]   cy_in,
   input  logic [tfn_pkg::COORD_W-1:0]   cz_in,
   output tfn_pkg::stage_type            out_stage
);
   import tfn_pkg::*;

   logic [4:0] valid_ff;
   logic signed [EDGE_W-1:0] v1x_ff, v1y_ff, v1z_ff, v2x_ff, v2y_ff, v2z_ff;
   logic signed [PROD_W-1:0] pyz_ff, pzy_ff, pzx_ff, pxz_ff, pxy_ff, pyx_ff;
   logic signed [CROSS_W-1:0] n_in [LANES];
   logic [MAG_W-1:0] m_ff [LANES];
   logic [LANES-1:0] neg3_ff, neg4_ff, neg5_ff;
   logic deg3_ff, deg4_ff, deg5_ff;
   logic [SQ_W-1:0] sq_ff [LANES];
   logic [SQ_W-1:0] len2_ff;
   logic [SQ_W-1:0] r_ff [LANES];

   always_comb begin
      n_in[0] = CROSS_W'(pyz_ff) - CROSS_W'(pzy_ff);
      n_in[1] = CROSS_W'(pzx_ff) - CROSS_W'(pxz_ff);
      n_in[2] = CROSS_W'(pxy_ff) - CROSS_W'(pyx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      v1x_ff <= $signed({ax[COORD_W-1], ax}) - $signed({bx[COORD_W-1], bx});
      v1y_ff <= $signed({ay[COORD_W-1], ay}) - $signed({by_coord[COORD_W-1], by_coord});
      v1z_ff <= $signed({az[COORD_W-1], az}) - $signed({bz[COORD_W-1], bz});
      v2x_ff <= $signed({bx[COORD_W-1], bx}) - $signed({cx_in[COORD_W-1], cx_in});
      v2y_ff <= $signed({by_coord[COORD_W-1], by_coord}) - $signed({cy_in[COORD_W-1], cy_in});
      v2z_ff <= $signed({bz[COORD_W-1], bz}) - $signed({cz_in[COORD_W-1], cz_in});

      pyz_ff <= v1y_ff * v2z_ff;
      pzy_ff <= v1z_ff * v2y_ff;
      pzx_ff <= v1z_ff * v2x_ff;
      pxz_ff <= v1x_ff * v2z_ff;
      pxy_ff <= v1x_ff * v2y_ff;
      pyx_ff <= v1y_ff * v2x_ff;

      for (int i = 0; i < LANES; i++) begin
         neg3_ff[i] <= n_in[i][CROSS_W-1];
         m_ff[i]    <= n_in[i][CROSS_W-1] ? MAG_W'(-n_in[i]) : MAG_W'(n_in[i]);
      end
      deg3_ff <= (n_in[0] == '0) && (n_in[1] == '0) && (n_in[2] == '0);

      for (int i = 0; i < LANES; i++) begin
         sq_ff[i] <= SQ_W'(m_ff[i]) * SQ_W'(m_ff[i]);
      end
      neg4_ff <= neg3_ff;
      deg4_ff <= deg3_ff;

      len2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      for (int i = 0; i < LANES; i++) begin
         r_ff[i] <= sq_ff[i];
      end
      neg5_ff <= neg4_ff;
      deg5_ff <= deg4_ff;
   end

   always_comb begin
      out_stage.valid = valid_ff[4];
      out_stage.deg   = deg5_ff;
      out_stage.neg   = neg5_ff;
      out_stage.len2  = len2_ff;
      for (int i = 0; i < LANES; i++) begin
         out_stage.lane[i].rem = ACC_W'(r_ff[i]) << FRAC_SH;
         out_stage.lane[i].acc = '0;
         out_stage.lane[i].q   = '0;
      end
   end
endmodule

@@ rtl/tfn_digit.sv @@
// One quotient bit of the normalisation, restoring form, all three lanes.
module tfn_digit #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  tfn_pkg::stage_type in_stage,
   output tfn_pkg::stage_type out_stage
);
   import tfn_pkg::*;

   stage_type stage_ff, stage_in;
   logic [ACC_W-1:0] trial [LANES];

   always_comb begin
      stage_in = in_stage;
      for (int i = 0; i < LANES; i++) begin
         // (q + 2^k)^2 L2 - q^2 L2 = L2 2^2k + 2^(k+1) q L2
         trial[i] = (ACC_W'(in_stage.len2) << (2 * BIT))
                  + (ACC_W'(in_stage.lane[i].acc) << (BIT + 1));
         if (in_stage.lane[i].rem >= trial[i]) begin
            stage_in.lane[i].rem = in_stage.lane[i].rem - trial[i];
            stage_in.lane[i].acc = in_stage.lane[i].acc
                                 + (SUM_W'(in_stage.len2) << BIT);
            stage_in.lane[i].q   = in_stage.lane[i].q | (QBITS'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.deg  <= stage_in.deg;
      stage_ff.neg  <= stage_in.neg;
      stage_ff.len2 <= stage_in.len2;
      stage_ff.lane <= stage_in.lane;
   end

   assign out_stage = stage_ff;
endmodule

@@ rtl/triangle_face_normal.sv @@
// Top level: unit face normal of a triangle, fully pipelined.
//
//  channel  ports                          handshake
//  request  start, busy, req_*             taken when start high and busy low
//  response rsp_valid, rsp_*               one-cycle strobe, no back-pressure
//
// One transaction per clock; busy is never raised.
// Pipeline: 5 front stages, 15 quotient-bit stages, output register.
// Synchronous reset clears the valid bits only; transactions in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module triangle_face_normal (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tfn_pkg::COORD_W-1:0]   req_ax,
   input  logic [tfn_pkg::COORD_W-1:0]   req_ay,
   input  logic [tfn_pkg::COORD_W-1:0]   req_az,
   input  logic [tfn_pkg::COORD_W-1:0]   req_bx,
   input  logic [tfn_pkg::COORD_W-1:0]   req_by_coord,
   input  logic [tfn_pkg::COORD_W-1:0]   req_bz,
   input  logic [tfn_pkg::COORD_W-1:0]   req_cx_in,
   input  logic [tfn_pkg::COORD_W-1:0]   req_cy_in,
   input  logic [tfn_pkg::COORD_W-1:0]   req_cz_in,
   output logic                          rsp_valid,
   output logic [tfn_pkg::OUT_W-1:0]     rsp_normal_x,
   output logic [tfn_pkg::OUT_W-1:0]     rsp_normal_y,
   output logic [tfn_pkg::OUT_W-1:0]     rsp_normal_z,
   output logic                          rsp_degenerate
);
   import tfn_pkg::*;

   stage_type pipe [QBITS+1];
   logic valid_ff;
   logic deg_ff;
   logic [OUT_W-1:0] norm_ff [LANES];
   logic [OUT_W-1:0] mag_in [LANES];

   assign busy = 1'b0;

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .ax        (req_ax),
      .ay        (req_ay),
      .az        (req_az),
      .bx        (req_bx),
      .by_coord  (req_by_coord),
      .bz        (req_bz),
      .cx_in     (req_cx_in),
      .cy_in     (req_cy_in),
      .cz_in     (req_cz_in),
      .out_stage (pipe[0])
   );

   for (genvar g = 0; g < QBITS; g++) begin : g_digit
      tfn_digit #(.BIT(QBITS - 1 - g)) u_digit (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (pipe[g]),
         .out_stage (pipe[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mag_in[i] = OUT_W'(pipe[QBITS].lane[i].q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pipe[QBITS].valid;
      end
      deg_ff <= pipe[QBITS].deg;
      for (int i = 0; i < LANES; i++) begin
         if (pipe[QBITS].deg) begin
            norm_ff[i] <= '0;
         end else if (pipe[QBITS].neg[i]) begin
            norm_ff[i] <= -mag_in[i];
         end else begin
            norm_ff[i] <= mag_in[i];
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_degenerate = deg_ff;
   assign rsp_normal_x   = norm_ff[0];
   assign rsp_normal_y   = norm_ff[1];
   assign rsp_normal_z   = norm_ff[2];
endmodule

@@ rtl/tfn_checker.sv @@
// Port-level checker for the triangle face normal block, with its bind.
module tfn_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [tfn_pkg::OUT_W-1:0]   rsp_normal_x,
   input logic [tfn_pkg::OUT_W-1:0]   rsp_normal_y,
   input logic [tfn_pkg::OUT_W-1:0]   rsp_normal_z,
   input logic                        rsp_degenerate
);
   import tfn_pkg::*;

   localparam logic [OUT_W-1:0] ONE_POS = OUT_W'(16384);
   localparam logic [OUT_W-1:0] ONE_NEG = OUT_W'(-16384);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without request");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate response not zero");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed(rsp_normal_x) <= $signed(ONE_POS) &&
          $signed(rsp_normal_x) >= $signed(ONE_NEG)) &&
         ($signed(rsp_normal_y) <= $signed(ONE_POS) &&
          $signed(rsp_normal_y) >= $signed(ONE_NEG)) &&
         ($signed(rsp_normal_z) <= $signed(ONE_POS) &&
          $signed(rsp_normal_z) >= $signed(ONE_NEG)))
      else $error("normal component out of range");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate)
);

@@ test/tb_top.sv @@
// Testbench: checks the triangle face normal block against its own normal predictor.
`timescale 1ns / 1ps

module tb_top;
   import tfn_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] v [9];
   } triangle_t;

   typedef struct {
      logic [OUT_W-1:0] nx, ny, nz;
      logic             deg;
   } normal_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [COORD_W-1:0] req_ax = '0, req_ay = '0, req_az = '0;
   logic [COORD_W-1:0] req_bx = '0, req_by_coord = '0, req_bz = '0;
   logic [COORD_W-1:0] req_cx_in = '0, req_cy_in = '0, req_cz_in = '0;
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   triangle_face_normal DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   triangle_t pending_tris[$];
   normal_t   expected_normals[$];
   int        errors = 0;
   int        sent = 0;
   int        checked = 0;
   int        degenerate_seen = 0;
   int        cycles = 0;
   bit        stimulus_done = 1'b0;
   bit        hold_for_drain = 1'b0;
   bit        taken = 1'b0;

   function automatic logic [OUT_W-1:0] unit_component(longint signed c, logic [127:0] len2);
      logic [127:0] rhs;
      logic [127:0] m;
      longint unsigned lo, hi, mid;
      m = (c < 0) ? -c : c;
      rhs = (m * m) << 28;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (len2 * (mid * mid) <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return (c < 0) ? OUT_W'(-lo) : OUT_W'(lo);
   endfunction

   function automatic normal_t face_normal(triangle_t t);
      longint signed p [9];
      longint signed v1x, v1y, v1z, v2x, v2y, v2z, nx, ny, nz;
      logic signed [127:0] wx, wy, wz;
      logic [127:0] len2;
      normal_t r;
      foreach (p[i]) p[i] = longint'($signed(t.v[i]));
      v1x = p[0] - p[3]; v1y = p[1] - p[4]; v1z = p[2] - p[5];
      v2x = p[3] - p[6]; v2y = p[4] - p[7]; v2z = p[5] - p[8];
      nx = v1y * v2z - v1z * v2y;
      ny = v1z * v2x - v1x * v2z;
      nz = v1x * v2y - v1y * v2x;
      if (nx == 0 && ny == 0 && nz == 0) begin
         r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
         return r;
      end
      wx = 128'(nx);
      wy = 128'(ny);
      wz = 128'(nz);
      len2 = wx * wx + wy * wy + wz * wz;
      r.nx = unit_component(nx, len2);
      r.ny = unit_component(ny, len2);
      r.nz = unit_component(nz, len2);
      r.deg = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (transaction %0d)", what,
               $signed(got), $signed(want), checked);
   endtask

   // driver
   int gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         start <= 1'b1;
      end else if (gap > 0) begin
         start <= 1'b0;
         gap <= gap - 1;
      end else if (!(hold_for_drain && expected_normals.size() != 0) &&
                   pending_tris.size() != 0) begin
         triangle_t t;
         t = pending_tris.pop_front();
         req_ax       <= t.v[0];
         req_ay       <= t.v[1];
         req_az       <= t.v[2];
         req_bx       <= t.v[3];
         req_by_coord <= t.v[4];
         req_bz       <= t.v[5];
         req_cx_in    <= t.v[6];
         req_cy_in    <= t.v[7];
         req_cz_in    <= t.v[8];
         start <= 1'b1;
         gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end else begin
         start <= 1'b0;
      end
   end

   // acceptance and monitor
   always @(posedge clock) begin
      cycles++;
      taken = !reset && start && !busy;
      if (taken) begin
         triangle_t t;
         t.v = '{req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz,
                 req_cx_in, req_cy_in, req_cz_in};
         expected_normals.push_back(face_normal(t));
         sent++;
      end
      if (!reset && rsp_valid) begin
         if (expected_normals.size() == 0) begin
            errors++;
            $display("unexpected transaction on the response side");
         end else begin
            normal_t w;
            w = expected_normals.pop_front();
            if (rsp_normal_x !== w.nx) report_mismatch("normal_x", rsp_normal_x, w.nx);
            if (rsp_normal_y !== w.ny) report_mismatch("normal_y", rsp_normal_y, w.ny);
            if (rsp_normal_z !== w.nz) report_mismatch("normal_z", rsp_normal_z, w.nz);
            if (rsp_degenerate !== w.deg)
               report_mismatch("degenerate", OUT_W'(rsp_degenerate), OUT_W'(w.deg));
            if (w.deg) degenerate_seen++;
            checked++;
         end
      end
   end

   task automatic add_tri(input logic [COORD_W-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
      triangle_t t;
      t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
      pending_tris.push_back(t);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return COORD_W'($urandom);
         1: return COORD_W'($urandom_range(0, 64) - 32);
         2: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
         default: return COORD_W'($urandom_range(0, 8192) - 4096);
      endcase
   endfunction

   initial begin
      triangle_t t;
      int mode;
      // directed: extremes, axis-aligned normals, degenerate shapes
      add_tri(0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000, 0);
      add_tri(0, 0, 0, 0, 16'h1000, 0, 16'h1000, 0, 0);
      add_tri(0, 0, 0, 0, 0, 16'h1000, 16'h1000, 0, 0);
      add_tri(0, 0, 0, 16'h1000, 0, 0, 0, 0, 16'h1000);
      add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1, 2, 3);
      add_tri(0, 0, 0, 16'h1000, 16'h1000, 16'h1000, 16'h2000, 16'h2000, 16'h2000);
      add_tri(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
              16'h7fff, 16'h7fff, 16'h8000);
      add_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000);
      add_tri(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
              16'h8000, 16'h7fff, 16'h7fff);
      add_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 1, 0, 0);
      add_tri(1, 2, 3, 4, 5, 6, 16'h7000, 16'h8123, 16'h0fff);
      add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
      add_tri(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0, 0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 1500; i++) begin
         if (i == 700) begin
            wait (pending_tris.size() == 0);
            hold_for_drain = 1'b1;
         end
         mode = $urandom_range(0, 3);
         foreach (t.v[k]) t.v[k] = rand_coord(mode);
         if ($urandom_range(0, 19) == 0) begin
            // collinear: C = B + (B - A)
            foreach (t.v[k]) if (k >= 6) t.v[k] = COORD_W'(2 * t.v[k-3] - t.v[k-6]);
            if (mode == 0 || mode == 2) foreach (t.v[k]) t.v[k] = rand_coord(1);
            if (mode == 0 || mode == 2)
               foreach (t.v[k])
                  if (k >= 6) t.v[k] = COORD_W'(2 * t.v[k-3] - t.v[k-6]);
         end
         pending_tris.push_back(t);
         if (i == 701) begin
            wait (pending_tris.size() == 0);
            hold_for_drain = 1'b0;
         end
      end
      wait (pending_tris.size() == 0 && !start);
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      wait (expected_normals.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d triangles sent, %0d normals checked, %0d degenerate", sent, checked,
               degenerate_seen);
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      wait (cycles >= 200000);
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
   end
endmodule

@@ triangle_face_normal.f @@
rtl/tfn_pkg.sv
rtl/tfn_front.sv
rtl/tfn_digit.sv
rtl/triangle_face_normal.sv
rtl/tfn_checker.sv
test/tb_top.sv
